// ===== rtl/core/fsmcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsmcc_pkg
// Shared types, constants and the free-space class encoder for the
// free-space map with class cache.
// ----------------------------------------------------------------------------
package fsmcc_pkg;

    localparam int PAGE_BYTES        = 4096;
    localparam int DEFAULT_MAX_PAGES = 65536;
    localparam int NUM_CLASSES       = 16;
    localparam int LIN_STEP          = PAGE_BYTES / 16 + 1;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_FIND    = 2'd1,
        ACT_REBUILD = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_UPDATE  = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_REBUILD = 7'b0010000,
        S_FIND    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    // Smallest byte count of each logarithmic class: ceil(PAGE_BYTES^(k/8))
    typedef logic [12:0] t_thr [1:7];
    localparam t_thr LOG_THR = '{13'd3, 13'd8, 13'd23, 13'd64,
                                 13'd182, 13'd512, 13'd1449};

    // Log classes below half a page, linear classes above, saturated at 15
    function automatic logic [3:0] f_encode(input logic [12:0] bytes);
        logic [3:0]  cls;
        logic [31:0] step;
        cls = 4'd0;
        if ({19'd0, bytes} < 32'(PAGE_BYTES / 2)) begin
            for (int k = 1; k <= 7; k++) begin
                if (bytes >= LOG_THR[k]) begin
                    cls = 4'(k);
                end
            end
        end else begin
            for (int m = 1; m < NUM_CLASSES; m++) begin
                step = 32'(LIN_STEP * m);
                if ({19'd0, bytes} >= step) begin
                    cls = 4'(m);
                end
            end
        end
        return cls;
    endfunction

endpackage

// ===== rtl/core/fsmcc_ram.sv =====
// ----------------------------------------------------------------------------
// fsmcc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fsmcc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/free_space_map_with_class_cache_unit.sv =====
// ----------------------------------------------------------------------------
// free_space_map_with_class_cache_unit
// Per-page free-space class map with a cache of the earliest page per class.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_stall carries action, page_index and free_bytes.
// Output channel: o_valid/i_stall carries found, result_page, space_class,
// one result transaction per input transaction, in order.
// Config channel: i_cfg_valid/o_cfg_ready writes pages_in_use (always ready);
// write it only while the block is idle.
// After reset a clearing pass writes class 0 to every map entry, one entry a
// cycle, while o_stall stays high.
// Find and the unused action go through S_FIND; update writes the map entry and,
// when the page was the earliest of its old class, scans the map forward from
// the next page for that class; rebuild scans min(pages_in_use, MAX_PAGES)
// map entries. The scans read the map memory one entry a cycle.
// One transaction is in work at a time; a finished result sits in the output
// register, so the next transaction is accepted while i_stall holds it.
// ----------------------------------------------------------------------------
module free_space_map_with_class_cache_unit #(
    parameter int P_MAX_PAGES = fsmcc_pkg::DEFAULT_MAX_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_page_index,
    input  logic [12:0] i_free_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [15:0] o_result_page,
    output logic [3:0]  o_space_class,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);
    import fsmcc_pkg::*;

    localparam int AW = $clog2(P_MAX_PAGES);
    localparam int SW = $clog2(P_MAX_PAGES + 1);

    t_state           r_state;
    logic [16:0]      r_piu;
    t_action          r_action;
    logic [15:0]      r_page;
    logic [3:0]       r_cls;
    logic [3:0]       r_old;
    logic [SW-1:0]    r_addr;
    logic             r_rd_vld;
    logic [SW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_clr;
    logic [NUM_CLASSES-1:0] r_cvld;
    logic [AW-1:0]    r_cpage [NUM_CLASSES];
    logic             r_res_found;
    logic [15:0]      r_res_page;
    logic             r_ov;
    logic             r_found;
    logic [15:0]      r_rpage;
    logic [3:0]       r_scls;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [3:0]       ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [3:0]       ram_rdata;

    logic [31:0]      lim;
    logic [31:0]      page_w;
    logic [31:0]      next_w;
    logic             page_ok;
    logic             hit_any;
    logic [3:0]       hit_idx;
    logic             fnd_any;
    logic [3:0]       fnd_idx;
    logic [31:0]      fnd_page_w;
    logic [31:0]      rd_addr_w;
    logic             issue;
    logic             out_free;

    // Scan bound and page range
    always_comb begin
        lim = ({15'd0, r_piu} < 32'(P_MAX_PAGES)) ? {15'd0, r_piu} : 32'(P_MAX_PAGES);
        page_w  = {16'd0, r_page};
        next_w  = page_w + 32'd1;
        page_ok = page_w < 32'(P_MAX_PAGES);
        issue   = {{(32 - SW){1'b0}}, r_addr} < lim;
        rd_addr_w = {{(32 - SW){1'b0}}, r_rd_addr};
        out_free  = !r_ov || !i_stall;
    end

    // Locate the cache entry that names the updated page
    always_comb begin
        hit_any = 1'b0;
        hit_idx = 4'd0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (r_cvld[i] && ({{(32 - AW){1'b0}}, r_cpage[i]} == page_w)) begin
                hit_any = 1'b1;
                hit_idx = 4'(i);
            end
        end
    end

    // First valid class at or above the requested one
    always_comb begin
        fnd_any = 1'b0;
        fnd_idx = 4'd0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (r_cvld[i] && (4'(i) >= r_cls)) begin
                fnd_any = 1'b1;
                fnd_idx = 4'(i);
            end
        end
        fnd_page_w = {{(32 - AW){1'b0}}, r_cpage[fnd_idx]};
    end

    // Map memory port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 4'd0;
        ram_raddr = r_addr[AW-1:0];
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_UPDATE) begin
            ram_we    = page_ok;
            ram_waddr = page_w[AW-1:0];
            ram_wdata = r_cls;
        end
    end

    fsmcc_ram #(
        .WIDTH (4),
        .DEPTH (P_MAX_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer, cache and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(P_MAX_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= t_action'(i_action);
                        r_page   <= i_page_index;
                        r_cls    <= f_encode(i_free_bytes);
                        unique case (t_action'(i_action))
                            ACT_UPDATE:  r_state <= S_UPDATE;
                            ACT_REBUILD: begin
                                r_cvld   <= '0;
                                r_addr   <= '0;
                                r_rd_vld <= 1'b0;
                                r_state  <= S_REBUILD;
                            end
                            ACT_FIND, ACT_NONE: r_state <= S_FIND;
                        endcase
                    end
                end
                S_UPDATE: begin
                    r_res_found <= 1'b1;
                    r_res_page  <= 16'd0;
                    r_state     <= S_DONE;
                    if (page_ok) begin
                        if (!r_cvld[r_cls] ||
                            (page_w < {{(32 - AW){1'b0}}, r_cpage[r_cls]})) begin
                            r_cvld[r_cls]  <= 1'b1;
                            r_cpage[r_cls] <= page_w[AW-1:0];
                        end
                        if (hit_any && (hit_idx != r_cls)) begin
                            r_old    <= hit_idx;
                            r_rd_vld <= 1'b0;
                            if (next_w < lim) begin
                                r_addr  <= next_w[SW-1:0];
                                r_state <= S_SCAN;
                            end else begin
                                r_cvld[hit_idx]  <= 1'b0;
                                r_cpage[hit_idx] <= '0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_vld  <= issue;
                    r_rd_addr <= r_addr;
                    r_addr    <= r_addr + 1'b1;
                    if (r_rd_vld && (ram_rdata == r_old)) begin
                        r_cpage[r_old] <= rd_addr_w[AW-1:0];
                        r_rd_vld       <= 1'b0;
                        r_state        <= S_DONE;
                    end else if (!issue) begin
                        r_cvld[r_old]  <= 1'b0;
                        r_cpage[r_old] <= '0;
                        r_rd_vld       <= 1'b0;
                        r_state        <= S_DONE;
                    end
                end
                S_REBUILD: begin
                    r_rd_vld  <= issue;
                    r_rd_addr <= r_addr;
                    r_addr    <= r_addr + 1'b1;
                    if (r_rd_vld && !r_cvld[ram_rdata]) begin
                        r_cvld[ram_rdata]  <= 1'b1;
                        r_cpage[ram_rdata] <= rd_addr_w[AW-1:0];
                    end
                    if (!issue) begin
                        r_rd_vld    <= 1'b0;
                        r_res_found <= 1'b1;
                        r_res_page  <= 16'd0;
                        r_state     <= S_DONE;
                    end
                end
                S_FIND: begin
                    if ((r_action == ACT_FIND) && fnd_any) begin
                        r_res_found <= 1'b1;
                        r_res_page  <= fnd_page_w[15:0];
                    end else begin
                        r_res_found <= 1'b0;
                        r_res_page  <= 16'd0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_found <= r_res_found;
            r_rpage <= r_res_page;
            r_scls  <= r_cls;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= '0;
        end else if (i_cfg_valid) begin
            r_piu <= i_cfg_data;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_found       = r_found;
    assign o_result_page = r_rpage;
    assign o_space_class = r_scls;
    assign o_cfg_ready   = 1'b1;

`ifndef SYNTHESIS
    a_scan_old_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_old != r_cls))
        else $error("forward scan runs for the page's new class");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov)
        else $error("stalled result transaction dropped");
    a_clear_leaves_cache_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) ##1 (r_state == S_IDLE)) |-> (r_cvld == '0))
        else $error("cache holds entries after clearing pass");
    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_ov && i_stall) |=> (r_state == S_DONE))
        else $error("result left done state while output register full");
`endif

endmodule
